[hw/rtl/ptc_pkg.sv]
// shared types, constants and coding for the pressure/temperature compensator
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int OUT_DEPTH_DEFAULT   = 2;

   // latency of one wrapping 64-bit multiply, and quotient bits of the divider
   localparam int MUL_LAT  = 2;
   localparam int DIV_BITS = 64;

   localparam int FINE_OFFSET = 128000;
   localparam int PRESS_BASE  = 1048576;
   localparam int PRESS_SCALE = 3125;

   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CALIB_TEMP    = 2'd0,
      CSR_CALIB_PRESS_A = 2'd1,
      CSR_CALIB_PRESS_B = 2'd2,
      CSR_CALIB_PRESS_C = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } calib_type;

   // item handed from the temperature front end to the pressure back end
   typedef struct packed {
      logic signed [31:0] fine;
      logic signed [15:0] tc;
      logic        [19:0] adc_p;
   } mid_item_type;

   typedef struct packed {
      logic signed [15:0] temperature_centi;
      logic        [31:0] pressure_q24_8;
   } rsp_item_type;

   typedef struct packed {
      logic [63:0] un;
      logic [30:0] ud;
      logic        neg;
      logic        dz;
   } div_in_type;

endpackage

`default_nettype wire

[hw/rtl/pressure_temperature_compensator.sv]
// top level: calibration registers, front end, queue, back end and result queue
//
//   channel  ports                                           transfer when
//   req      req_push req_full req_raw_temperature/pressure  req_push & !req_full
//   rsp      rsp_pop rsp_empty rsp_temperature_centi/..q24_8 rsp_pop & !rsp_empty
//   csr      csr_we csr_index csr_wdata                      csr_we
//
// one raw pair a cycle is taken in while req_full is low; a result passes 5 front
// and 78 back stages, mostly the 64-stage divider, and waits in the two queues
// reset clears calibration to zero and empties both queues and all stage valids
// a stalled result queue freezes the back pipeline; the middle queue absorbs the
// front end's output until it fills, then req_full rises
`timescale 1ns / 1ps
`default_nettype none

module pressure_temperature_compensator import ptc_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int OUT_DEPTH   = OUT_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [19:0]            req_raw_temperature,
   input  logic [19:0]            req_raw_pressure,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic signed [15:0]     rsp_temperature_centi,
   output logic [31:0]            rsp_pressure_q24_8,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [47:0] calib_temp_ff;
   logic [63:0] calib_press_a_ff;
   logic [63:0] calib_press_b_ff;
   logic [15:0] calib_press_c_ff;
   calib_type   calib;

   logic         mid_push, mid_full, mid_pop, mid_empty;
   mid_item_type mid_in_item, mid_out_item;
   logic         out_push, out_full;
   rsp_item_type out_in_item, out_out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_temp_ff    <= '0;
         calib_press_a_ff <= '0;
         calib_press_b_ff <= '0;
         calib_press_c_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CALIB_TEMP:    calib_temp_ff    <= csr_wdata[47:0];
            CSR_CALIB_PRESS_A: calib_press_a_ff <= csr_wdata;
            CSR_CALIB_PRESS_B: calib_press_b_ff <= csr_wdata;
            CSR_CALIB_PRESS_C: calib_press_c_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      calib.t1 = calib_temp_ff[15:0];
      calib.t2 = calib_temp_ff[31:16];
      calib.t3 = calib_temp_ff[47:32];
      calib.p1 = calib_press_a_ff[15:0];
      calib.p2 = calib_press_a_ff[31:16];
      calib.p3 = calib_press_a_ff[47:32];
      calib.p4 = calib_press_a_ff[63:48];
      calib.p5 = calib_press_b_ff[15:0];
      calib.p6 = calib_press_b_ff[31:16];
      calib.p7 = calib_press_b_ff[47:32];
      calib.p8 = calib_press_b_ff[63:48];
      calib.p9 = calib_press_c_ff;
   end

   ptc_front u_front (
      .clock, .reset, .req_push, .req_full, .req_raw_temperature, .req_raw_pressure,
      .calib, .mid_push, .mid_item(mid_in_item), .mid_full
   );

   ptc_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(mid_item_type))) u_mid_queue (
      .clock, .reset, .push(mid_push), .din(mid_in_item), .full(mid_full),
      .pop(mid_pop), .dout(mid_out_item), .empty(mid_empty)
   );

   ptc_back u_back (
      .clock, .reset, .calib, .mid_item(mid_out_item), .mid_empty, .mid_pop,
      .out_push, .out_item(out_in_item), .out_full
   );

   ptc_fifo #(.DEPTH(OUT_DEPTH), .WIDTH($bits(rsp_item_type))) u_out_queue (
      .clock, .reset, .push(out_push), .din(out_in_item), .full(out_full),
      .pop(rsp_pop), .dout(out_out_item), .empty(rsp_empty)
   );

   assign rsp_temperature_centi = out_out_item.temperature_centi;
   assign rsp_pressure_q24_8    = out_out_item.pressure_q24_8;

   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      mid_push |-> !mid_full)
      else $error("front end pushed into a full queue");

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("back end pushed into a full result queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

endmodule

`default_nettype wire

[hw/rtl/ptc_fifo.sv]
// small register queue with push/full and pop/empty sides
`timescale 1ns / 1ps
`default_nettype none

module ptc_fifo import ptc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/ptc_front.sv]
// front end: accepts raw pairs, works out fine temperature and centidegrees
`timescale 1ns / 1ps
`default_nettype none

module ptc_front import ptc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic [19:0]  req_raw_temperature,
   input  logic [19:0]  req_raw_pressure,
   input  calib_type    calib,
   output logic         mid_push,
   output mid_item_type mid_item,
   input  logic         mid_full
);

   logic [4:0] vld_ff;
   logic       adv;

   logic signed [18:0] x1_in, x1_ff;
   logic signed [17:0] d_in, d_ff;
   logic signed [34:0] ma_in, ma_ff;
   logic signed [35:0] dsq_in, dsq_ff;
   logic signed [34:0] a_in, a_ff;
   logic signed [39:0] mb_in, mb_ff;
   logic signed [39:0] fine_w;
   logic signed [31:0] fine_ff;
   logic signed [35:0] t5_w, tcw_w;
   logic signed [15:0] tc_in;
   logic [19:0]        adcp_ff [4];
   mid_item_type       item_ff;

   assign adv      = !(vld_ff[4] && mid_full);
   assign req_full = !adv;
   assign mid_push = vld_ff[4] && !mid_full;
   assign mid_item = item_ff;

   assign x1_in  = $signed({2'b00, req_raw_temperature[19:3]})
                 - $signed({2'b00, calib.t1, 1'b0});
   assign d_in   = $signed({2'b00, req_raw_temperature[19:4]}) - $signed({2'b00, calib.t1});
   assign ma_in  = x1_ff * calib.t2;
   assign dsq_in = d_ff * d_ff;
   assign a_in   = ma_ff >>> 11;
   assign mb_in  = (dsq_ff >>> 12) * calib.t3;
   assign fine_w = a_ff + (mb_ff >>> 14);
   assign t5_w   = fine_ff * 36'sd5 + 36'sd128;
   assign tcw_w  = t5_w >>> 8;

   always_comb begin
      if (tcw_w > 36'sd32767) begin
         tc_in = 16'sh7fff;
      end else if (tcw_w < -36'sd32768) begin
         tc_in = 16'sh8000;
      end else begin
         tc_in = tcw_w[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[3:0], req_push};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff      <= x1_in;
         d_ff       <= d_in;
         adcp_ff[0] <= req_raw_pressure;
         ma_ff      <= ma_in;
         dsq_ff     <= dsq_in;
         adcp_ff[1] <= adcp_ff[0];
         a_ff       <= a_in;
         mb_ff      <= mb_in;
         adcp_ff[2] <= adcp_ff[1];
         fine_ff    <= fine_w[31:0];
         adcp_ff[3] <= adcp_ff[2];
         item_ff.fine  <= fine_ff;
         item_ff.tc    <= tc_in;
         item_ff.adc_p <= adcp_ff[3];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/ptc_mul64.sv]
// two-stage multiply giving the low 64 bits of a 64 by 64 product
`timescale 1ns / 1ps
`default_nettype none

module ptc_mul64 import ptc_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);

   logic [63:0] ll_ff;
   logic [63:0] lh_w, hl_w;
   logic [31:0] lh_ff, hl_ff;
   logic [63:0] p_ff;

   // the high-by-high term lies wholly above bit 63
   assign lh_w = a[31:0] * b[63:32];
   assign hl_w = a[63:32] * b[31:0];
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= a[31:0] * b[31:0];
         lh_ff <= lh_w[31:0];
         hl_ff <= hl_w[31:0];
         p_ff  <= ll_ff + {lh_ff + hl_ff, 32'b0};
      end
   end

endmodule

`default_nettype wire

[hw/rtl/ptc_div.sv]
// pipelined restoring divider, one quotient bit per stage, sign and zero flags ride along
`timescale 1ns / 1ps
`default_nettype none

module ptc_div import ptc_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  div_in_type  din,
   output logic [63:0] q,
   output logic        neg,
   output logic        dz
);

   typedef struct packed {
      logic [30:0] rem;
      logic [63:0] nq;
      logic [30:0] ud;
      logic        neg;
      logic        dz;
   } div_stage_type;

   div_stage_type stg_ff [DIV_BITS];
   div_stage_type stg_in [DIV_BITS];
   div_stage_type first_w;

   assign first_w = '{rem: '0, nq: din.un, ud: din.ud, neg: din.neg, dz: din.dz};

   for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
      div_stage_type prev;
      logic [31:0]   rem2;
      logic [31:0]   diff;
      logic          ge;

      if (i == 0) begin : g_first
         assign prev = first_w;
      end else begin : g_next
         assign prev = stg_ff[i-1];
      end

      // numerator bits leave at the top of nq while quotient bits enter below
      assign rem2 = {prev.rem, prev.nq[63]};
      assign diff = rem2 - {1'b0, prev.ud};
      assign ge   = (rem2 >= {1'b0, prev.ud});

      always_comb begin
         stg_in[i]     = prev;
         stg_in[i].rem = ge ? diff[30:0] : rem2[30:0];
         stg_in[i].nq  = {prev.nq[62:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   assign q   = stg_ff[DIV_BITS-1].nq;
   assign neg = stg_ff[DIV_BITS-1].neg;
   assign dz  = stg_ff[DIV_BITS-1].dz;

endmodule

`default_nettype wire

[hw/rtl/ptc_back.sv]
// back end: 64-bit wrapping pressure pipeline with divider and saturation
`timescale 1ns / 1ps
`default_nettype none

module ptc_back import ptc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  calib_type    calib,
   input  mid_item_type mid_item,
   input  logic         mid_empty,
   output logic         mid_pop,
   output logic         out_push,
   output rsp_item_type out_item,
   input  logic         out_full
);

   localparam int BACK_LAT = DIV_BITS + 4 * MUL_LAT + 6;

   logic [BACK_LAT-1:0] vld_ff;
   logic signed [15:0]  tc_ff [BACK_LAT];
   logic                adv;

   logic [63:0] p3s, p4s, p6s, p7s, p8s, p9s, p1z;

   logic signed [31:0] v1_w;
   logic signed [24:0] v1_ff;
   logic [20:0]        pr_in;
   logic [20:0]        pr_ff [MUL_LAT+2];
   logic signed [49:0] sq_in, sq_ff;
   logic signed [40:0] m5_in, m2_in;
   logic signed [40:0] m5_ff [MUL_LAT+1];
   logic signed [40:0] m2_ff [MUL_LAT+1];
   logic [63:0]        r6, r3, r3_sh, v2_w, t_w, num0_w;
   logic [63:0]        t_ff, num0_ff;
   logic [63:0]        prod_c, num_d;
   div_in_type         div_in, div_ff;
   logic [30:0]        dv_w;
   logic [63:0]        q_w;
   logic               neg_w, dz_w;
   logic [63:0]        p_in, x_in;
   logic [63:0]        p_ff  [2*MUL_LAT+1];
   logic               dz_ff [2*MUL_LAT+1];
   logic [63:0]        x_ff  [MUL_LAT+1];
   logic [63:0]        prod_e, prod_f, prod_g;
   logic [63:0]        pf_ff [MUL_LAT];
   logic [63:0]        ga_w, fb_w, s1_w, s1_sh, sum_w;
   logic [31:0]        pres_in, pres_ff;

   assign adv      = !(vld_ff[BACK_LAT-1] && out_full);
   assign mid_pop  = adv && !mid_empty;
   assign out_push = vld_ff[BACK_LAT-1] && !out_full;
   assign out_item = '{temperature_centi: tc_ff[BACK_LAT-1], pressure_q24_8: pres_ff};

   assign p1z = {48'b0, calib.p1};
   assign p3s = {{48{calib.p3[15]}}, calib.p3};
   assign p4s = {{48{calib.p4[15]}}, calib.p4};
   assign p6s = {{48{calib.p6[15]}}, calib.p6};
   assign p7s = {{48{calib.p7[15]}}, calib.p7};
   assign p8s = {{48{calib.p8[15]}}, calib.p8};
   assign p9s = {{48{calib.p9[15]}}, calib.p9};

   // offset fine temperature stays well inside 25 bits
   assign v1_w  = mid_item.fine - 32'(FINE_OFFSET);
   assign pr_in = 21'(PRESS_BASE) - {1'b0, mid_item.adc_p};
   assign sq_in = v1_ff * v1_ff;
   assign m5_in = v1_ff * calib.p5;
   assign m2_in = v1_ff * calib.p2;

   ptc_mul64 u_mul_p6 (.clock, .en(adv), .a({{14{sq_ff[49]}}, sq_ff}), .b(p6s), .p(r6));
   ptc_mul64 u_mul_p3 (.clock, .en(adv), .a({{14{sq_ff[49]}}, sq_ff}), .b(p3s), .p(r3));

   assign r3_sh  = $signed(r3) >>> 8;
   assign v2_w   = r6 + ({{23{m5_ff[MUL_LAT][40]}}, m5_ff[MUL_LAT]} << 17) + (p4s << 35);
   assign t_w    = r3_sh + ({{23{m2_ff[MUL_LAT][40]}}, m2_ff[MUL_LAT]} << 12)
                 + (64'd1 << 47);
   assign num0_w = {12'b0, pr_ff[MUL_LAT+1], 31'b0} - v2_w;

   ptc_mul64 u_mul_p1    (.clock, .en(adv), .a(t_ff),    .b(p1z),               .p(prod_c));
   ptc_mul64 u_mul_scale (.clock, .en(adv), .a(num0_ff), .b(64'(PRESS_SCALE)), .p(num_d));

   // divisor is the top 31 bits of the product, i.e. an arithmetic shift by 33
   assign dv_w = prod_c[63:33];

   always_comb begin
      div_in.un  = num_d[63] ? 64'd0 - num_d : num_d;
      div_in.ud  = dv_w[30] ? 31'd0 - dv_w : dv_w;
      div_in.neg = num_d[63] ^ dv_w[30];
      div_in.dz  = (dv_w == '0);
   end

   ptc_div u_div (.clock, .en(adv), .din(div_ff), .q(q_w), .neg(neg_w), .dz(dz_w));

   assign p_in = neg_w ? 64'd0 - q_w : q_w;
   assign x_in = $signed(p_in) >>> 13;

   ptc_mul64 u_mul_p9 (.clock, .en(adv), .a(p9s),    .b(x_ff[0]),       .p(prod_e));
   ptc_mul64 u_mul_p8 (.clock, .en(adv), .a(p8s),    .b(p_ff[0]),       .p(prod_f));
   ptc_mul64 u_mul_sq (.clock, .en(adv), .a(prod_e), .b(x_ff[MUL_LAT]), .p(prod_g));

   assign ga_w  = $signed(prod_g) >>> 25;
   assign fb_w  = $signed(pf_ff[MUL_LAT-1]) >>> 19;
   assign s1_w  = p_ff[2*MUL_LAT] + ga_w + fb_w;
   assign s1_sh = $signed(s1_w) >>> 8;
   assign sum_w = s1_sh + (p7s << 4);

   always_comb begin
      if (dz_ff[2*MUL_LAT] || sum_w[63]) begin
         pres_in = '0;
      end else if (|sum_w[62:32]) begin
         pres_in = '1;
      end else begin
         pres_in = sum_w[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[BACK_LAT-2:0], !mid_empty};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tc_ff[0] <= mid_item.tc;
         for (int k = 1; k < BACK_LAT; k++) begin
            tc_ff[k] <= tc_ff[k-1];
         end
         v1_ff    <= v1_w[24:0];
         pr_ff[0] <= pr_in;
         for (int k = 1; k < MUL_LAT + 2; k++) begin
            pr_ff[k] <= pr_ff[k-1];
         end
         sq_ff    <= sq_in;
         m5_ff[0] <= m5_in;
         m2_ff[0] <= m2_in;
         for (int k = 1; k < MUL_LAT + 1; k++) begin
            m5_ff[k] <= m5_ff[k-1];
            m2_ff[k] <= m2_ff[k-1];
         end
         t_ff    <= t_w;
         num0_ff <= num0_w;
         div_ff  <= div_in;
         p_ff[0]  <= p_in;
         dz_ff[0] <= dz_w;
         for (int k = 1; k < 2 * MUL_LAT + 1; k++) begin
            p_ff[k]  <= p_ff[k-1];
            dz_ff[k] <= dz_ff[k-1];
         end
         x_ff[0] <= x_in;
         for (int k = 1; k < MUL_LAT + 1; k++) begin
            x_ff[k] <= x_ff[k-1];
         end
         pf_ff[0] <= prod_f;
         for (int k = 1; k < MUL_LAT; k++) begin
            pf_ff[k] <= pf_ff[k-1];
         end
         pres_ff <= pres_in;
      end
   end

endmodule

`default_nettype wire
